>>> rtl/vfpf_pkg.sv
package vfpf_pkg;

  localparam int unsigned SET_DEPTH = 4096;
  localparam int unsigned ADDR_W    = $clog2(SET_DEPTH);
  localparam int unsigned CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned EDGE_W    = 25;
  localparam int unsigned KEY_W     = 3 * COORD_W;
  localparam int unsigned STEP_W    = $clog2(COORD_W);
  localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(256);

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic        [31:0]        intensity_bits;
    logic                      new_cloud;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic        [31:0]        out_intensity;
    logic                      keep;
    logic                      set_full;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture item, arm dividers
    logic div_step;   // one quotient bit on all three axes
    logic srch_init;  // rewind the key scan
    logic srch_step;  // advance the key scan
    logic hit;        // key found: drop
    logic miss;       // key not found: insert or flag full
    logic out_load;   // move result into output register
  } vfpf_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic match;
    logic exhausted;
  } vfpf_sts_t;

endpackage

>>> rtl/vfpf_ram.sv
module vfpf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/vfpf_ctrl.sv
module vfpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  vfpf_pkg::vfpf_sts_t sts,
  output vfpf_pkg::vfpf_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SRCH = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [vfpf_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r - 1'b1;
        if (step_r == '0) begin
          cmd.srch_init = 1'b1;
          state_nxt     = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_FIN;
        end else if (sts.exhausted) begin
          cmd.miss  = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/vfpf_dpath.sv
module vfpf_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vfpf_pkg::in_item_t                 in_data,
  output vfpf_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  input  logic [vfpf_pkg::EDGE_W-1:0]        cfg_data,
  input  vfpf_pkg::vfpf_cmd_t                cmd,
  output vfpf_pkg::vfpf_sts_t                sts
);

  localparam int unsigned CW = vfpf_pkg::COORD_W;
  localparam int unsigned EW = vfpf_pkg::EDGE_W;

  vfpf_pkg::in_item_t                item_r;
  vfpf_pkg::out_item_t               out_r;
  logic [EW-1:0]                     edge_r;
  logic [EW-1:0]                     edge_eff;
  logic [vfpf_pkg::CNT_W-1:0]        count_r;
  logic [vfpf_pkg::CNT_W-1:0]        ptr_r;
  logic                              chk_r;
  logic                              keep_r;
  logic                              full_r;
  logic                              ptr_lt;
  logic                              room;
  logic [CW-1:0]                     quo_r [3];
  logic [EW-1:0]                     rem_r [3];
  logic                              neg_r [3];
  logic [CW-1:0]                     key   [3];
  logic [CW-1:0]                     mag   [3];
  logic [vfpf_pkg::KEY_W-1:0]        key_vec;
  logic [vfpf_pkg::KEY_W-1:0]        rd_key;
  logic                              wr_en;

  assign edge_eff = (edge_r == '0) ? EW'(1) : edge_r;

  assign mag[0] = in_data.coord_x[CW-1] ? (~in_data.coord_x + 1'b1) : in_data.coord_x;
  assign mag[1] = in_data.coord_y[CW-1] ? (~in_data.coord_y + 1'b1) : in_data.coord_y;
  assign mag[2] = in_data.coord_z[CW-1] ? (~in_data.coord_z + 1'b1) : in_data.coord_z;

  // one restoring divider per axis, magnitude in, floor applied on the way out
  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [EW:0] trial;
    logic [EW:0] diff;
    logic        ge;

    assign trial = {rem_r[l], quo_r[l][CW-1]};
    assign diff  = trial - {1'b0, edge_eff};
    assign ge    = (trial >= {1'b0, edge_eff});

    // negative: -q when exact, -q-1 (= ~q) otherwise
    assign key[l] = !neg_r[l] ? quo_r[l] :
                    (rem_r[l] != '0) ? ~quo_r[l] : (~quo_r[l] + 1'b1);

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        quo_r[l] <= mag[l];
        rem_r[l] <= '0;
      end else if (cmd.div_step) begin
        quo_r[l] <= {quo_r[l][CW-2:0], ge};
        rem_r[l] <= ge ? diff[EW-1:0] : trial[EW-1:0];
      end
    end
  end

  assign key_vec = {key[0], key[1], key[2]};
  assign ptr_lt  = (ptr_r < count_r);
  assign room    = (count_r < vfpf_pkg::CNT_W'(vfpf_pkg::SET_DEPTH));
  assign wr_en   = cmd.miss && room;

  assign sts.match     = chk_r && (rd_key == key_vec);
  assign sts.exhausted = !chk_r && !ptr_lt;

  vfpf_ram #(
    .WIDTH (vfpf_pkg::KEY_W),
    .DEPTH (vfpf_pkg::SET_DEPTH)
  ) u_keys (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[vfpf_pkg::ADDR_W-1:0]),
    .wr_data (key_vec),
    .rd_addr (ptr_r[vfpf_pkg::ADDR_W-1:0]),
    .rd_data (rd_key)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r  <= vfpf_pkg::EDGE_RESET;
      count_r <= '0;
    end else begin
      if (cfg_valid) begin
        edge_r <= cfg_data;
      end
      if (cmd.load && in_data.new_cloud) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r   <= in_data;
      neg_r[0] <= in_data.coord_x[CW-1];
      neg_r[1] <= in_data.coord_y[CW-1];
      neg_r[2] <= in_data.coord_z[CW-1];
    end
    if (cmd.srch_init) begin
      ptr_r <= '0;
      chk_r <= 1'b0;
    end else if (cmd.srch_step) begin
      chk_r <= ptr_lt;
      if (ptr_lt) begin
        ptr_r <= ptr_r + 1'b1;
      end
    end
    if (cmd.hit) begin
      keep_r <= 1'b0;
      full_r <= 1'b0;
    end else if (cmd.miss) begin
      keep_r <= room;
      full_r <= !room;
    end
    if (cmd.out_load) begin
      out_r.out_x         <= item_r.coord_x;
      out_r.out_y         <= item_r.coord_y;
      out_r.out_z         <= item_r.coord_z;
      out_r.out_intensity <= item_r.intensity_bits;
      out_r.keep          <= keep_r;
      out_r.set_full      <= full_r;
    end
  end

  assign out_data = out_r;

endmodule

>>> rtl/voxel_first_point_filter_unit.sv
// Voxel first-point filter. Each input transaction is one point (Q23.8 x, y, z plus raw
// intensity); each yields exactly one output transaction carrying the point unchanged with
// keep = 1 if its voxel key floor(coord / voxel_edge) was new and got inserted, or
// set_full = 1 if the key was new but all 4096 key slots are taken. new_cloud empties the
// set before the point is handled. Points are handled one at a time: the idle state takes
// the point, three 32-step restoring dividers run side by side, then the key store memory
// is scanned linearly, one entry per cycle, over the N keys held so far, then the finish
// state posts the result once the output register is free. For large clouds the key scan
// dominates the time an item takes. The result sits in an output register, so the next
// point's work can overlap a stalled output.
// voxel_edge must be written through cfg_* only while idle; the block itself does not
// enforce this. A value of 0 acts as 1.
module voxel_first_point_filter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // point input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  vfpf_pkg::in_item_t                 in_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output vfpf_pkg::out_item_t                out_data,
  // voxel_edge write
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vfpf_pkg::EDGE_W-1:0]        cfg_data
);

  vfpf_pkg::vfpf_cmd_t cmd;
  vfpf_pkg::vfpf_sts_t sts;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  // sequencing: accept, divide, scan, post
  vfpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // dividers, key store, fill count, output register
  vfpf_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> rtl/vfpf_checker.sv
module vfpf_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input vfpf_pkg::out_item_t out_data
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a pending result does not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // kept and full are exclusive
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.keep && out_data.set_full))
    else $error("keep and set_full both set");

  // one point in flight: an accepted point closes the input
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second point accepted while busy");

endmodule

bind voxel_first_point_filter_unit vfpf_checker u_vfpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> test/vfpf_checker.sv
`timescale 1ns / 100ps

module vfpf_scoreboard (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  vfpf_pkg::in_item_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  vfpf_pkg::out_item_t         out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [vfpf_pkg::EDGE_W-1:0] cfg_data,
  output int                          fail_count,
  output int                          results_owed,
  output int                          kept_count,
  output int                          full_count
);

  logic [vfpf_pkg::EDGE_W-1:0] edge_len;
  logic [vfpf_pkg::KEY_W-1:0]  seen_keys [vfpf_pkg::SET_DEPTH];
  int                          seen_count;
  vfpf_pkg::out_item_t         owed_q [$];

  // floor(c / e), with e = 0 taken as 1, truncated to 32 bits
  function automatic logic [vfpf_pkg::COORD_W-1:0] voxel_index(
      logic signed [vfpf_pkg::COORD_W-1:0] c, logic [vfpf_pkg::EDGE_W-1:0] e);
    longint q, r, d;
    d = (e == '0) ? 1 : longint'(e);
    q = longint'(c) / d;
    r = longint'(c) % d;
    if (r != 0 && c < 0) q = q - 1;
    return q[vfpf_pkg::COORD_W-1:0];
  endfunction

  function automatic vfpf_pkg::out_item_t filter_point(vfpf_pkg::in_item_t p);
    vfpf_pkg::out_item_t        res;
    logic [vfpf_pkg::KEY_W-1:0] k;
    bit                         hit;
    hit = 0;
    if (p.new_cloud) seen_count = 0;
    k = {voxel_index(p.coord_x, edge_len), voxel_index(p.coord_y, edge_len),
         voxel_index(p.coord_z, edge_len)};
    for (int i = 0; i < seen_count; i++)
      if (seen_keys[i] == k) begin
        hit = 1;
        break;
      end
    res.out_x = p.coord_x;
    res.out_y = p.coord_y;
    res.out_z = p.coord_z;
    res.out_intensity = p.intensity_bits;
    res.keep = 0;
    res.set_full = 0;
    if (!hit) begin
      if (seen_count < vfpf_pkg::SET_DEPTH) begin
        seen_keys[seen_count] = k;
        seen_count++;
        res.keep = 1;
      end else begin
        res.set_full = 1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    vfpf_pkg::out_item_t want;
    if (!rst_n) begin
      edge_len   <= vfpf_pkg::EDGE_RESET;
      seen_count = 0;
      owed_q.delete();
      fail_count   <= 0;
      kept_count   <= 0;
      full_count   <= 0;
      results_owed <= 0;
    end else begin
      if (cfg_valid && cfg_ready) edge_len <= cfg_data;
      if (in_valid && !in_stall) owed_q = {owed_q, filter_point(in_data)};
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, actual %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = owed_q.pop_front();
          if (want !== out_data) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_data);
            fail_count <= fail_count + 1;
          end
          kept_count <= kept_count + out_data.keep;
          full_count <= full_count + out_data.set_full;
        end
      end
      results_owed <= owed_q.size();
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_LIMIT = 20000;  // well above the longest point, a key scan over a full key set

  logic                        clk = 0;
  logic                        rst_n = 0;
  logic                        in_valid = 0;
  logic                        in_stall;
  vfpf_pkg::in_item_t          in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 0;
  vfpf_pkg::out_item_t         out_data;
  logic                        cfg_valid = 0;
  logic                        cfg_ready;
  logic [vfpf_pkg::EDGE_W-1:0] cfg_data = '0;

  int  fail_count, results_owed, kept_count, full_count;
  int  points_sent;
  int  idle_cycles = 0;
  bit  no_idle;  // quiet stretch: both sides run flat out
  logic [vfpf_pkg::EDGE_W-1:0] cur_edge;

  always #5 clk = ~clk;

  voxel_first_point_filter_unit dut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  vfpf_scoreboard chk (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data,
    .fail_count, .results_owed, .kept_count, .full_count
  );

  // receiver backpressure, ~16% of cycles unless in the quiet stretch
  always @(posedge clk)
    out_stall <= !no_idle && ($urandom_range(99) < 16);

  // watchdog: cycles with no transaction on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("TB_ERROR");
      $finish;
    end
  end

  // one point transaction; valid stays up into the next point unless we idle
  task automatic send_point(vfpf_pkg::in_item_t p);
    int gap;
    in_data  <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    points_sent++;
    if (!no_idle && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);  // block is back in idle before any cfg write
  endtask

  task automatic write_edge(logic [vfpf_pkg::EDGE_W-1:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_edge = v;
  endtask

  function automatic vfpf_pkg::in_item_t mk_point(int x, int y, int z, logic [31:0] inten,
                                                  bit nc);
    vfpf_pkg::in_item_t p;
    p.coord_x = x;
    p.coord_y = y;
    p.coord_z = z;
    p.intensity_bits = inten;
    p.new_cloud = nc;
    return p;
  endfunction

  // mostly near a cluster center so voxels repeat; some full-range and extreme values
  function automatic logic [31:0] pick_coord(int center);
    int     mode;
    longint span;
    logic [31:0] ext [4];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    mode = $urandom_range(99);
    span = (cur_edge == 0) ? 1 : longint'(cur_edge);
    if (span > 64'd100000000) span = 100000000;
    if (mode < 75) return 32'(longint'(center) + longint'($urandom_range(0, 4 * span)) - 2 * span);
    if (mode < 92) return $urandom;
    return ext[$urandom_range(3)];
  endfunction

  task automatic random_phase(int n);
    int cx, cy, cz;
    bit nc;
    for (int i = 0; i < n; i++) begin
      nc = ($urandom_range(99) < 6) || (i == 0);
      if (nc || $urandom_range(99) < 10) begin
        cx = $urandom; cy = $urandom; cz = $urandom;
      end
      send_point(mk_point(pick_coord(cx), pick_coord(cy), pick_coord(cz), $urandom, nc));
    end
  endtask

  initial begin
    logic [vfpf_pkg::EDGE_W-1:0] edges [6];
    edges = '{25'd1, 25'd0, 25'd256, 25'd16777216, 25'h1FF_FFFF, 25'd0};
    points_sent = 0;
    no_idle = 0;
    cur_edge = vfpf_pkg::EDGE_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset edge, floor on negatives, duplicates, clear, extremes
    send_point(mk_point(0, 0, 0, 32'h0, 1'b1));
    send_point(mk_point(255, 128, 1, 32'hFFFF_FFFF, 1'b0));    // same voxel: dropped
    send_point(mk_point(-1, 0, 0, 32'h1234_5678, 1'b0));       // key -1
    send_point(mk_point(-256, 0, 0, 32'h0, 1'b0));             // still -1
    send_point(mk_point(-257, 0, 0, 32'h0, 1'b0));             // key -2
    send_point(mk_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hA5A5_A5A5, 1'b0));
    send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b0));
    send_point(mk_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b0));
    send_point(mk_point(0, 0, 0, 32'h0, 1'b1));                // cleared: kept again
    send_point(mk_point(-1, -1, -1, 32'hFFFF_FFFF, 1'b0));
    drain();

    // random phases across edge settings, last one random
    edges[5] = $urandom_range(2, 25'h1FF_FFFF);
    foreach (edges[k]) begin
      write_edge(edges[k]);
      no_idle = (k == 2);
      random_phase(240);
      drain();
    end
    no_idle = 0;
    write_edge(vfpf_pkg::EDGE_RESET);
    random_phase(60);
    drain();
    repeat (50) @(posedge clk);

    $display("Covered %0d points over 7 voxel edge settings incl. 0, 1 and max.", points_sent);
    $display("Kept %0d, set-full flags %0d.", kept_count, full_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
